@@ hdl/dad_pkg.sv @@
// shared types, constants and tables for the torsion angle pipeline
`timescale 1ns / 1ps
package dad_pkg;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int CROSS_W   = 2 * DIFF_W + 1;
    localparam int BSQ_W     = 2 * DIFF_W + 2;
    localparam int BLEN_W    = BSQ_W / 2;
    localparam int BA_W      = BLEN_W + DIFF_W;
    localparam int PROD_W    = BA_W + CROSS_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int MAG_W     = ACC_W;
    localparam int SIG_BITS  = 30;
    localparam int CW        = SIG_BITS + 3;
    localparam int ZW        = 26;
    localparam int STEPS     = 16;
    localparam int FRAC      = 7;
    localparam int ANG_W     = 16;
    localparam int SQRT_STEPS = BLEN_W;

    localparam logic signed [ZW-1:0] Z_90 = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] LIM = ZW'(180 << FRAC);

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [CW-1:0] cord_t;
    typedef logic signed [ZW-1:0] ang_t;

    function automatic ang_t atan_deg(input int i);
        ang_t r;
        r = '0;
        unique case (i)
            0: r = ZW'(2949120);
            1: r = ZW'(1740967);
            2: r = ZW'(919879);
            3: r = ZW'(466945);
            4: r = ZW'(234379);
            5: r = ZW'(117304);
            6: r = ZW'(58666);
            7: r = ZW'(29335);
            8: r = ZW'(14668);
            9: r = ZW'(7334);
            10: r = ZW'(3667);
            11: r = ZW'(1833);
            12: r = ZW'(917);
            13: r = ZW'(458);
            14: r = ZW'(229);
            15: r = ZW'(115);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

@@ hdl/dihedral_angle_degrees.sv @@
// top level: torsion angle of four points, fully pipelined
// throughput: one request per cycle; the whole pipeline holds when the output stalls
// depth is set by the 18-stage square root and the 16-stage cordic
// reset: asynchronous active low, clears all valid bits; no clearing pass
`timescale 1ns / 1ps
module dihedral_angle_degrees (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] c_x,
    input  logic signed [15:0] c_y,
    input  logic signed [15:0] c_z,
    input  logic signed [15:0] d_x,
    input  logic signed [15:0] d_y,
    input  logic signed [15:0] d_z,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [15:0] torsion_deg,
    output logic degenerate
);
    logic en;
    logic signed [dad_pkg::COORD_W-1:0] p [12];
    logic g_v, d_v, c_v;
    dad_pkg::diff_t a_w [3];
    dad_pkg::cross_t ab_w [3], bc_w [3];
    logic [dad_pkg::BLEN_W-1:0] blen_w;
    dad_pkg::cord_t xv_w, yv_w;
    logic dg_w;

    assign en = out_ready || !c_v;
    assign in_ready = en;
    assign out_valid = c_v;

    assign p = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z};

    dad_geom u_geom (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid && in_ready), .p(p),
        .out_valid(g_v), .a_o(a_w), .ab_o(ab_w), .bc_o(bc_w), .blen_o(blen_w)
    );

    dad_dot u_dot (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(g_v), .a_i(a_w), .ab_i(ab_w),
        .bc_i(bc_w), .blen_i(blen_w), .out_valid(d_v), .xv_o(xv_w), .yv_o(yv_w),
        .degen_o(dg_w)
    );

    dad_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_v), .xv_i(xv_w), .yv_i(yv_w),
        .degen_i(dg_w), .out_valid(c_v), .angle_o(torsion_deg), .degen_o(degenerate)
    );

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(torsion_deg))
        else $error("output changed under stall");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> torsion_deg == '0)
        else $error("degenerate angle not zero");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> torsion_deg <= 16'sd23040 && torsion_deg >= -16'sd23040)
        else $error("angle out of range");
`endif
endmodule

@@ hdl/dad_geom.sv @@
// front stages: bond vectors, cross products, squared length, integer square root
`timescale 1ns / 1ps
module dad_geom (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [dad_pkg::COORD_W-1:0] p [12],
    output logic out_valid,
    output dad_pkg::diff_t a_o [3],
    output dad_pkg::cross_t ab_o [3],
    output dad_pkg::cross_t bc_o [3],
    output logic [dad_pkg::BLEN_W-1:0] blen_o
);
    localparam int NS = dad_pkg::SQRT_STEPS;
    localparam int SL = 1 + NS;

    dad_pkg::diff_t a1_reg [3], b1_reg [3], c1_reg [3];
    logic v_reg [SL];
    dad_pkg::diff_t a_reg [SL][3];
    dad_pkg::cross_t ab_reg [SL][3], bc_reg [SL][3];
    logic [dad_pkg::BSQ_W-1:0] rem_reg [SL];
    logic [dad_pkg::BLEN_W-1:0] root_reg [SL];
    logic v1_reg;

    dad_pkg::cross_t ab_next [3], bc_next [3];
    logic [dad_pkg::BSQ_W-1:0] bsq_next;

    always_comb
    begin
        ab_next[0] = dad_pkg::CROSS_W'(a1_reg[1] * b1_reg[2]) - dad_pkg::CROSS_W'(a1_reg[2] * b1_reg[1]);
        ab_next[1] = dad_pkg::CROSS_W'(a1_reg[2] * b1_reg[0]) - dad_pkg::CROSS_W'(a1_reg[0] * b1_reg[2]);
        ab_next[2] = dad_pkg::CROSS_W'(a1_reg[0] * b1_reg[1]) - dad_pkg::CROSS_W'(a1_reg[1] * b1_reg[0]);
        bc_next[0] = dad_pkg::CROSS_W'(b1_reg[1] * c1_reg[2]) - dad_pkg::CROSS_W'(b1_reg[2] * c1_reg[1]);
        bc_next[1] = dad_pkg::CROSS_W'(b1_reg[2] * c1_reg[0]) - dad_pkg::CROSS_W'(b1_reg[0] * c1_reg[2]);
        bc_next[2] = dad_pkg::CROSS_W'(b1_reg[0] * c1_reg[1]) - dad_pkg::CROSS_W'(b1_reg[1] * c1_reg[0]);
        bsq_next = dad_pkg::BSQ_W'(b1_reg[0] * b1_reg[0]) + dad_pkg::BSQ_W'(b1_reg[1] * b1_reg[1])
                 + dad_pkg::BSQ_W'(b1_reg[2] * b1_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int s = 0; s < SL; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v_reg[0] <= v1_reg;
            for (int s = 1; s < SL; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a1_reg[k] <= dad_pkg::DIFF_W'(p[3+k]) - dad_pkg::DIFF_W'(p[k]);
                b1_reg[k] <= dad_pkg::DIFF_W'(p[6+k]) - dad_pkg::DIFF_W'(p[3+k]);
                c1_reg[k] <= dad_pkg::DIFF_W'(p[9+k]) - dad_pkg::DIFF_W'(p[6+k]);
                a_reg[0][k] <= a1_reg[k];
                ab_reg[0][k] <= ab_next[k];
                bc_reg[0][k] <= bc_next[k];
            end
            rem_reg[0] <= bsq_next;
            root_reg[0] <= '0;
            for (int s = 1; s < SL; s++)
            begin
                logic [dad_pkg::BSQ_W-1:0] trial;
                logic [dad_pkg::BSQ_W-1:0] bitv;
                a_reg[s] <= a_reg[s-1];
                ab_reg[s] <= ab_reg[s-1];
                bc_reg[s] <= bc_reg[s-1];
                bitv = dad_pkg::BSQ_W'(1) << (2 * (NS - s));
                trial = (dad_pkg::BSQ_W'(root_reg[s-1]) << (NS - s + 1)) | bitv;
                if (rem_reg[s-1] >= trial)
                begin
                    rem_reg[s] <= rem_reg[s-1] - trial;
                    root_reg[s] <= root_reg[s-1] | (dad_pkg::BLEN_W'(1) << (NS - s));
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    root_reg[s] <= root_reg[s-1];
                end
            end
        end
    end

    assign out_valid = v_reg[SL-1];
    assign a_o = a_reg[SL-1];
    assign ab_o = ab_reg[SL-1];
    assign bc_o = bc_reg[SL-1];
    assign blen_o = root_reg[SL-1];
endmodule

@@ hdl/dad_dot.sv @@
// middle stages: the two dot products and magnitude normalization
`timescale 1ns / 1ps
module dad_dot (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  dad_pkg::diff_t a_i [3],
    input  dad_pkg::cross_t ab_i [3],
    input  dad_pkg::cross_t bc_i [3],
    input  logic [dad_pkg::BLEN_W-1:0] blen_i,
    output logic out_valid,
    output dad_pkg::cord_t xv_o,
    output dad_pkg::cord_t yv_o,
    output logic degen_o
);
    localparam int LW = $clog2(dad_pkg::MAG_W + 1);

    logic v_reg [6];
    logic signed [dad_pkg::BA_W-1:0] ba_reg [3];
    dad_pkg::cross_t ab1_reg [3], bc1_reg [3];
    logic signed [dad_pkg::PROD_W-1:0] px_reg [3], py_reg [3];
    dad_pkg::acc_t wx_reg, wy_reg;
    logic [dad_pkg::MAG_W-1:0] mx_reg, my_reg;
    logic xn_reg, yn_reg, z3_reg;
    logic [LW-1:0] l_reg;
    logic [dad_pkg::MAG_W-1:0] mx4_reg, my4_reg;
    logic xn4_reg, yn4_reg, z4_reg;
    dad_pkg::cord_t xv_reg, yv_reg;
    logic z5_reg;

    logic [LW-1:0] l_next;
    logic [dad_pkg::MAG_W-1:0] ormag;

    always_comb
    begin
        ormag = mx_reg | my_reg;
        l_next = '0;
        for (int i = 0; i < dad_pkg::MAG_W; i++)
            if (ormag[i])
                l_next = LW'(i + 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int s = 0; s < 6; s++)
                v_reg[s] <= 1'b0;
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < 6; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ba_reg[k] <= dad_pkg::BA_W'($signed({1'b0, blen_i})) * dad_pkg::BA_W'(a_i[k]);
                ab1_reg[k] <= ab_i[k];
                bc1_reg[k] <= bc_i[k];
                px_reg[k] <= dad_pkg::PROD_W'(ba_reg[k]) * dad_pkg::PROD_W'(bc1_reg[k]);
                py_reg[k] <= dad_pkg::PROD_W'(ab1_reg[k]) * dad_pkg::PROD_W'(bc1_reg[k]);
            end
            wx_reg <= dad_pkg::ACC_W'(px_reg[0]) + dad_pkg::ACC_W'(px_reg[1]) + dad_pkg::ACC_W'(px_reg[2]);
            wy_reg <= dad_pkg::ACC_W'(py_reg[0]) + dad_pkg::ACC_W'(py_reg[1]) + dad_pkg::ACC_W'(py_reg[2]);
            xn_reg <= wx_reg[dad_pkg::ACC_W-1];
            yn_reg <= wy_reg[dad_pkg::ACC_W-1];
            mx_reg <= wx_reg[dad_pkg::ACC_W-1] ? dad_pkg::MAG_W'(-wx_reg) : dad_pkg::MAG_W'(wx_reg);
            my_reg <= wy_reg[dad_pkg::ACC_W-1] ? dad_pkg::MAG_W'(-wy_reg) : dad_pkg::MAG_W'(wy_reg);
            z3_reg <= (wx_reg == '0) && (wy_reg == '0);
            l_reg <= l_next;
            mx4_reg <= mx_reg;
            my4_reg <= my_reg;
            xn4_reg <= xn_reg;
            yn4_reg <= yn_reg;
            z4_reg <= z3_reg;
            begin
                logic [dad_pkg::MAG_W-1:0] ux, uy;
                if (l_reg > LW'(dad_pkg::SIG_BITS))
                begin
                    ux = mx4_reg >> (l_reg - LW'(dad_pkg::SIG_BITS));
                    uy = my4_reg >> (l_reg - LW'(dad_pkg::SIG_BITS));
                end
                else
                begin
                    ux = mx4_reg << (LW'(dad_pkg::SIG_BITS) - l_reg);
                    uy = my4_reg << (LW'(dad_pkg::SIG_BITS) - l_reg);
                end
                yv_reg <= xn4_reg ? -dad_pkg::CW'(ux) : dad_pkg::CW'(ux);
                xv_reg <= yn4_reg ? -dad_pkg::CW'(uy) : dad_pkg::CW'(uy);
            end
            z5_reg <= z4_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign xv_o = xv_reg;
    assign yv_o = yv_reg;
    assign degen_o = z5_reg;
endmodule

@@ hdl/dad_cordic.sv @@
// back stages: unrolled vectoring cordic, rounding and saturation
`timescale 1ns / 1ps
module dad_cordic (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  dad_pkg::cord_t xv_i,
    input  dad_pkg::cord_t yv_i,
    input  logic degen_i,
    output logic out_valid,
    output logic signed [dad_pkg::ANG_W-1:0] angle_o,
    output logic degen_o
);
    localparam int N = dad_pkg::STEPS;
    localparam int SL = N + 2;

    logic v_reg [SL];
    logic d_reg [SL];
    dad_pkg::cord_t x_reg [N+1], y_reg [N+1];
    dad_pkg::ang_t z_reg [N+1];
    logic signed [dad_pkg::ANG_W-1:0] ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int s = 0; s < SL; s++)
                v_reg[s] <= 1'b0;
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < SL; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= degen_i;
            for (int s = 1; s < SL; s++)
                d_reg[s] <= d_reg[s-1];
            if (xv_i < 0)
            begin
                if (yv_i >= 0)
                begin
                    x_reg[0] <= yv_i;
                    y_reg[0] <= -xv_i;
                    z_reg[0] <= dad_pkg::Z_90;
                end
                else
                begin
                    x_reg[0] <= -yv_i;
                    y_reg[0] <= xv_i;
                    z_reg[0] <= -dad_pkg::Z_90;
                end
            end
            else
            begin
                x_reg[0] <= xv_i;
                y_reg[0] <= yv_i;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < N; i++)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + dad_pkg::atan_deg(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - dad_pkg::atan_deg(i);
                end
            end
            begin
                dad_pkg::ang_t r;
                r = (z_reg[N] + dad_pkg::ZW'(1 << (15 - dad_pkg::FRAC))) >>> (16 - dad_pkg::FRAC);
                if (r > dad_pkg::LIM)
                    r = dad_pkg::LIM;
                if (r < -dad_pkg::LIM)
                    r = -dad_pkg::LIM;
                ang_reg <= d_reg[SL-2] ? '0 : dad_pkg::ANG_W'(r);
            end
        end
    end

    assign out_valid = v_reg[SL-1];
    assign angle_o = ang_reg;
    assign degen_o = d_reg[SL-1];
endmodule
